/* rtl/dmt_pkg.sv */
// shared types and constants of the detection marker tracker
`default_nettype none

package dmt_pkg;

	localparam int COORD_W   = 13;
	localparam int RECT_W    = 12;
	localparam int RAD_W     = 12;
	localparam int R2_W      = 24;
	localparam int LIFE_W    = 9;
	localparam int CFG_IDX_W = 2;
	localparam int TAG_IDX_W = 8;
	localparam int OUT_IDX_W = 6;

	localparam logic [1:0] ACT_FRAME_START = 2'd0;
	localparam logic [1:0] ACT_DETECT      = 2'd1;
	localparam logic [1:0] ACT_FRAME_END   = 2'd2;
	localparam logic [1:0] ACT_CLEAR       = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LIFETIME     = 2'd2;

	// reciprocal of five, exact for dividends below 2**18
	localparam logic [15:0] RECIP5 = 16'd52429;

	localparam logic signed [LIFE_W-1:0] LIFE_MIN = -9'sd256;

	typedef struct packed {
		logic [COORD_W-1:0]       x;
		logic [COORD_W-1:0]       y;
		logic signed [LIFE_W-1:0] life;
	} marker_t;

	typedef struct packed {
		logic                 valid;
		logic                 active;
		logic [TAG_IDX_W-1:0] idx;
	} slot_tag_t;

endpackage

`default_nettype wire

/* rtl/detection_marker_tracker_core.sv */
// top level of the detection marker tracker
`default_nettype none

// Tracks up to MARKER_SLOTS object markers. Marker position and life sit in
// one memory word per slot, the active flags in flip-flops. A clear drops every
// active flag and does not raise busy. A frame start or frame end sweeps the
// memory at one slot per cycle. A detection first passes through the scaling
// pipeline, then scans the slots at one memory read per cycle; it gives its one
// result on done once the last slot is compared, or as soon as an active marker
// matches. The result is shown for one cycle and cannot be held off. Other
// actions give no result. Configuration writes are always accepted and are
// meant for times when busy is low.

module detection_marker_tracker_core import dmt_pkg::*; #(
	parameter int MARKER_SLOTS = 50
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	output logic                      busy,
	input  wire logic [1:0]           action,
	input  wire logic [RECT_W-1:0]    rect_x,
	input  wire logic [RECT_W-1:0]    rect_y,
	input  wire logic [RECT_W-1:0]    rect_width,
	input  wire logic [RECT_W-1:0]    rect_height,
	output logic                      done,
	output logic [OUT_IDX_W-1:0]      marker_index,
	output logic                      slot_valid,
	output logic                      is_new,
	output logic [COORD_W-1:0]        center_x,
	output logic [COORD_W-1:0]        center_y,
	output logic [RAD_W-1:0]          radius,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [COORD_W-1:0]   cfg_data
);

	localparam int IW = (MARKER_SLOTS > 1) ? $clog2(MARKER_SLOTS) : 1;
	localparam int CW = $clog2(MARKER_SLOTS + 1);
	localparam logic [CW-1:0] SLOTS_C = CW'(MARKER_SLOTS);
	localparam logic [IW-1:0] LAST_C  = IW'(MARKER_SLOTS - 1);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_CALC  = 2'd1;
	localparam logic [1:0] ST_SWEEP = 2'd2;
	localparam logic [1:0] ST_SCAN  = 2'd3;

	logic [1:0]              state_q;
	logic [1:0]              act_q;
	logic [CW-1:0]           rd_q;
	logic                    v1_q;
	logic [IW-1:0]           idx_s1;
	logic                    act_s1;
	logic                    free_found_q;
	logic [IW-1:0]           free_idx_q;
	logic [MARKER_SLOTS-1:0] active_q;
	logic [COORD_W-1:0]      fw_q, fh_q;
	logic [7:0]              lifetime_q;
	logic                    done_q;
	logic [OUT_IDX_W-1:0]    index_q;
	logic                    slot_valid_q, is_new_q;
	logic [COORD_W-1:0]      center_x_q, center_y_q;
	logic [RAD_W-1:0]        radius_q;

	logic                    accept;
	logic                    issue;
	logic                    scale_done;
	logic [COORD_W-1:0]      cx, cy;
	logic [RAD_W-1:0]        rad;
	logic [R2_W-1:0]         r2;
	slot_tag_t               tag_in, tag_out;
	logic                    det_hit, det_last, insert_ok;
	logic [IW-1:0]           hit_idx;
	marker_t                 rd_word, wr_word, fresh_word;
	logic                    wr_en;
	logic [IW-1:0]           wr_addr;

	assign accept    = start && !busy;
	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;

	dmt_scale u_scale (
		.clk         (clk),
		.arst_n      (arst_n),
		.go          (accept && action == ACT_DETECT),
		.rect_x      (rect_x),
		.rect_y      (rect_y),
		.rect_width  (rect_width),
		.rect_height (rect_height),
		.done        (scale_done),
		.cx          (cx),
		.cy          (cy),
		.rad         (rad),
		.r2          (r2)
	);

	dmt_ram #(
		.WIDTH ($bits(marker_t)),
		.DEPTH (MARKER_SLOTS)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_word),
		.rd_addr (rd_q[IW-1:0]),
		.rd_data (rd_word)
	);

	assign tag_in = '{valid: v1_q && state_q == ST_SCAN && !det_hit,
		active: act_s1, idx: TAG_IDX_W'(idx_s1)};

	dmt_dist u_dist (
		.clk     (clk),
		.arst_n  (arst_n),
		.tag_in  (tag_in),
		.mx      (rd_word.x),
		.my      (rd_word.y),
		.cx      (cx),
		.cy      (cy),
		.r2      (r2),
		.tag_out (tag_out),
		.hit     (det_hit)
	);

	assign hit_idx    = IW'(tag_out.idx);
	assign det_last   = tag_out.valid && !det_hit && hit_idx == LAST_C;
	assign insert_ok  = free_found_q && cx <= fw_q && cy <= fh_q;
	assign issue      = (state_q == ST_SWEEP || state_q == ST_SCAN) && rd_q != SLOTS_C
		&& !det_hit;
	assign fresh_word = '{x: cx, y: cy, life: {1'b0, lifetime_q}};

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = idx_s1;
		wr_word = '{x: rd_word.x, y: rd_word.y, life: rd_word.life - 9'sd1};
		if (state_q == ST_SWEEP) begin
			wr_en = v1_q && act_q == ACT_FRAME_START && active_q[idx_s1]
				&& rd_word.life != LIFE_MIN;
		end else if (state_q == ST_SCAN) begin
			wr_word = fresh_word;
			if (det_hit) begin
				wr_en   = 1'b1;
				wr_addr = hit_idx;
			end else if (det_last && insert_ok) begin
				wr_en   = 1'b1;
				wr_addr = free_idx_q;
			end
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q       <= 13'd320;
			fh_q       <= 13'd240;
			lifetime_q <= 8'd5;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_FRAME_WIDTH:  fw_q <= cfg_data;
				CFG_FRAME_HEIGHT: fh_q <= cfg_data;
				CFG_LIFETIME: begin
					if (cfg_data[7:0] != 8'd0) begin
						lifetime_q <= cfg_data[7:0];
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			act_q        <= ACT_FRAME_START;
			rd_q         <= '0;
			v1_q         <= 1'b0;
			free_found_q <= 1'b0;
			active_q     <= '0;
			done_q       <= 1'b0;
		end else begin
			done_q <= 1'b0;
			v1_q   <= issue;
			if (issue) begin
				rd_q <= rd_q + 1'b1;
				if (state_q == ST_SCAN && !active_q[rd_q[IW-1:0]] && !free_found_q) begin
					free_found_q <= 1'b1;
				end
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						act_q <= action;
						rd_q  <= '0;
						case (action)
							ACT_CLEAR:  active_q <= '0;
							ACT_DETECT: state_q <= ST_CALC;
							default:    state_q <= ST_SWEEP;
						endcase
					end
				end
				ST_CALC: begin
					if (scale_done) begin
						state_q      <= ST_SCAN;
						rd_q         <= '0;
						free_found_q <= 1'b0;
					end
				end
				ST_SWEEP: begin
					if (v1_q && act_q == ACT_FRAME_END && active_q[idx_s1]
						&& rd_word.life[LIFE_W-1]) begin
						active_q[idx_s1] <= 1'b0;
					end
					if (rd_q == SLOTS_C && !v1_q) begin
						state_q <= ST_IDLE;
					end
				end
				ST_SCAN: begin
					if (det_hit || det_last) begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
					end
					if (det_last && insert_ok) begin
						active_q[free_idx_q] <= 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// slot pipeline and result payload
	always_ff @(posedge clk) begin
		if (issue) begin
			idx_s1 <= rd_q[IW-1:0];
			act_s1 <= active_q[rd_q[IW-1:0]];
			if (state_q == ST_SCAN && !active_q[rd_q[IW-1:0]] && !free_found_q) begin
				free_idx_q <= rd_q[IW-1:0];
			end
		end
		if (state_q == ST_SCAN && (det_hit || det_last)) begin
			center_x_q <= cx;
			center_y_q <= cy;
			radius_q   <= rad;
			if (det_hit) begin
				index_q      <= OUT_IDX_W'(hit_idx);
				slot_valid_q <= 1'b1;
				is_new_q     <= 1'b0;
			end else if (insert_ok) begin
				index_q      <= OUT_IDX_W'(free_idx_q);
				slot_valid_q <= 1'b1;
				is_new_q     <= 1'b1;
			end else begin
				index_q      <= '0;
				slot_valid_q <= 1'b0;
				is_new_q     <= 1'b0;
			end
		end
	end

	assign done         = done_q;
	assign marker_index = index_q;
	assign slot_valid   = slot_valid_q;
	assign is_new       = is_new_q;
	assign center_x     = center_x_q;
	assign center_y     = center_y_q;
	assign radius       = radius_q;

endmodule

`default_nettype wire

/* rtl/dmt_ram.sv */
// generic simple dual port ram with registered read
`default_nettype none

module dmt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

`default_nettype wire

/* rtl/dmt_scale.sv */
// pipelined scaling of a detection rectangle to center and radius
`default_nettype none

module dmt_scale import dmt_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               go,
	input  wire logic [RECT_W-1:0]  rect_x,
	input  wire logic [RECT_W-1:0]  rect_y,
	input  wire logic [RECT_W-1:0]  rect_width,
	input  wire logic [RECT_W-1:0]  rect_height,
	output logic                    done,
	output logic [COORD_W-1:0]      cx,
	output logic [COORD_W-1:0]      cy,
	output logic [RAD_W-1:0]        rad,
	output logic [R2_W-1:0]         r2
);

	logic [3:0]  v_q;
	logic [17:0] sx, sy;
	logic [16:0] sr;
	logic [17:0] nx_s1, ny_s1;
	logic [16:0] nr_s1;
	logic [31:0] px_s2, py_s2;
	logic [29:0] pr_s2;
	logic [COORD_W-1:0] cx_s3, cy_s3;
	logic [RAD_W-1:0]   rad_s3;
	logic [R2_W-1:0]    r2_s4;

	assign sx = {5'b0, rect_x, 1'b0} + {6'b0, rect_width};
	assign sy = {5'b0, rect_y, 1'b0} + {6'b0, rect_height};
	assign sr = {5'b0, rect_width} + {5'b0, rect_height};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			v_q <= {v_q[2:0], go};
		end
	end

	// each stage holds its value until the next transaction passes through
	always_ff @(posedge clk) begin
		if (go) begin
			nx_s1 <= sx * 18'd13 + 18'd10;
			ny_s1 <= sy * 18'd13 + 18'd10;
			nr_s1 <= sr * 17'd13 + 17'd20;
		end
		if (v_q[0]) begin
			px_s2 <= {16'b0, nx_s1[17:2]} * {16'b0, RECIP5};
			py_s2 <= {16'b0, ny_s1[17:2]} * {16'b0, RECIP5};
			pr_s2 <= {16'b0, nr_s1[16:3]} * {14'b0, RECIP5};
		end
		if (v_q[1]) begin
			cx_s3  <= px_s2[30:18];
			cy_s3  <= py_s2[30:18];
			rad_s3 <= pr_s2[29:18];
		end
		if (v_q[2]) begin
			r2_s4 <= {12'b0, rad_s3} * {12'b0, rad_s3};
		end
	end

	assign done = v_q[3];
	assign cx   = cx_s3;
	assign cy   = cy_s3;
	assign rad  = rad_s3;
	assign r2   = r2_s4;

endmodule

`default_nettype wire

/* rtl/dmt_dist.sv */
// squared distance stage and radius compare for the marker scan
`default_nettype none

module dmt_dist import dmt_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire slot_tag_t          tag_in,
	input  wire logic [COORD_W-1:0] mx,
	input  wire logic [COORD_W-1:0] my,
	input  wire logic [COORD_W-1:0] cx,
	input  wire logic [COORD_W-1:0] cy,
	input  wire logic [R2_W-1:0]    r2,
	output slot_tag_t               tag_out,
	output logic                    hit
);

	logic [COORD_W-1:0]   dx, dy;
	logic                 valid_s2;
	logic                 active_s2;
	logic [TAG_IDX_W-1:0] idx_s2;
	logic [2*COORD_W-1:0] sqx_s2, sqy_s2;
	logic [2*COORD_W:0]   dist2;

	assign dx = (cx >= mx) ? cx - mx : mx - cx;
	assign dy = (cy >= my) ? cy - my : my - cy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= tag_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		active_s2 <= tag_in.active;
		idx_s2    <= tag_in.idx;
		sqx_s2    <= {13'b0, dx} * {13'b0, dx};
		sqy_s2    <= {13'b0, dy} * {13'b0, dy};
	end

	assign dist2   = {1'b0, sqx_s2} + {1'b0, sqy_s2};
	assign tag_out = '{valid: valid_s2, active: active_s2, idx: idx_s2};
	assign hit     = valid_s2 && active_s2 && (dist2 <= {3'b0, r2});

endmodule

`default_nettype wire

/* rtl/dmt_checker.sv */
// port level assertions for the detection marker tracker and their binding
`default_nettype none

module dmt_checker import dmt_pkg::*; (
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 start,
	input wire logic                 busy,
	input wire logic [1:0]           action,
	input wire logic                 done,
	input wire logic                 slot_valid,
	input wire logic                 is_new,
	input wire logic [OUT_IDX_W-1:0] marker_index
);

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without a transaction in progress");

	a_busy_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && action != ACT_CLEAR) |=> busy)
		else $error("accepted transaction did not raise busy");

	a_single_result: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("more than one result for a transaction");

	a_new_has_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(done && is_new) |-> slot_valid)
		else $error("new marker without a slot");

	a_no_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !slot_valid) |-> (marker_index == '0 && !is_new))
		else $error("unassigned result carries a slot");

endmodule

bind detection_marker_tracker_core dmt_checker u_dmt_checker (.*);

`default_nettype wire

/* tb/sv/dmt_result_check.sv */
`timescale 1ns / 100ps
// result checker for the marker tracker: mirrors the marker table and compares every result
module dmt_result_check import dmt_pkg::*; #(
	parameter int MARKER_SLOTS = 50
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic                 busy,
	input  wire logic [1:0]           action,
	input  wire logic [RECT_W-1:0]    rect_x,
	input  wire logic [RECT_W-1:0]    rect_y,
	input  wire logic [RECT_W-1:0]    rect_width,
	input  wire logic [RECT_W-1:0]    rect_height,
	input  wire logic                 done,
	input  wire logic [OUT_IDX_W-1:0] marker_index,
	input  wire logic                 slot_valid,
	input  wire logic                 is_new,
	input  wire logic [COORD_W-1:0]   center_x,
	input  wire logic [COORD_W-1:0]   center_y,
	input  wire logic [RAD_W-1:0]     radius,
	input  wire logic                 cfg_valid,
	input  wire logic                 cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [COORD_W-1:0]   cfg_data,
	output int                        fail_count,
	output int                        outstanding
);

	typedef struct packed {
		logic [OUT_IDX_W-1:0] marker_index;
		logic                 slot_valid;
		logic                 is_new;
		logic [COORD_W-1:0]   center_x;
		logic [COORD_W-1:0]   center_y;
		logic [RAD_W-1:0]     radius;
	} detect_result_t;

	logic [COORD_W-1:0] frame_w;
	logic [COORD_W-1:0] frame_h;
	int                 life_reload;
	logic [COORD_W-1:0] pos_x [MARKER_SLOTS];
	logic [COORD_W-1:0] pos_y [MARKER_SLOTS];
	bit                 active [MARKER_SLOTS];
	int                 life [MARKER_SLOTS];
	detect_result_t     expected_q [$];
	detect_result_t     want;

	function automatic detect_result_t track_detection(input int rx, input int ry,
			input int rw, input int rh);
		detect_result_t res;
		int cx, cy, rad, dx, dy;
		bit hit;
		cx = ((2 * rx + rw) * 13 + 10) / 20;
		cy = ((2 * ry + rh) * 13 + 10) / 20;
		rad = ((rw + rh) * 13 + 20) / 40;
		res = '0;
		res.center_x = COORD_W'(cx);
		res.center_y = COORD_W'(cy);
		res.radius = RAD_W'(rad);
		hit = 1'b0;
		for (int i = 0; i < MARKER_SLOTS && !hit; i++) begin
			dx = cx - int'(pos_x[i]);
			dy = cy - int'(pos_y[i]);
			if (active[i] && dx * dx + dy * dy <= rad * rad) begin
				pos_x[i] = COORD_W'(cx);
				pos_y[i] = COORD_W'(cy);
				life[i] = life_reload;
				res.marker_index = OUT_IDX_W'(i);
				res.slot_valid = 1'b1;
				hit = 1'b1;
			end
		end
		if (!hit && cx <= int'(frame_w) && cy <= int'(frame_h)) begin
			for (int i = 0; i < MARKER_SLOTS && !hit; i++) begin
				if (!active[i]) begin
					pos_x[i] = COORD_W'(cx);
					pos_y[i] = COORD_W'(cy);
					active[i] = 1'b1;
					life[i] = life_reload;
					res.marker_index = OUT_IDX_W'(i);
					res.slot_valid = 1'b1;
					res.is_new = 1'b1;
					hit = 1'b1;
				end
			end
		end
		return res;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want_v,
			input logic [31:0] got_v);
		if (got_v !== want_v) begin
			$error("%s: expected %0d, got %0d", name, want_v, got_v);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_w = 13'd320;
			frame_h = 13'd240;
			life_reload = 5;
			for (int i = 0; i < MARKER_SLOTS; i++) begin
				pos_x[i] = '0;
				pos_y[i] = '0;
				active[i] = 1'b0;
				life[i] = 0;
			end
			expected_q.delete();
			fail_count = 0;
			outstanding = 0;
		end else begin
			if (done) begin
				if (expected_q.size() == 0) begin
					$error("result transaction with no detection pending");
					fail_count++;
				end else begin
					want = expected_q.pop_front();
					check_field("marker_index", 32'(want.marker_index), 32'(marker_index));
					check_field("slot_valid", 32'(want.slot_valid), 32'(slot_valid));
					check_field("is_new", 32'(want.is_new), 32'(is_new));
					check_field("center_x", 32'(want.center_x), 32'(center_x));
					check_field("center_y", 32'(want.center_y), 32'(center_y));
					check_field("radius", 32'(want.radius), 32'(radius));
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_FRAME_WIDTH: frame_w = cfg_data;
					CFG_FRAME_HEIGHT: frame_h = cfg_data;
					CFG_LIFETIME: begin
						if (cfg_data[7:0] != 8'd0)
							life_reload = int'(cfg_data[7:0]);
					end
					default: ;
				endcase
			end
			if (start && !busy) begin
				case (action)
					ACT_FRAME_START: begin
						for (int i = 0; i < MARKER_SLOTS; i++)
							if (active[i] && life[i] > int'(LIFE_MIN))
								life[i]--;
					end
					ACT_FRAME_END, ACT_CLEAR: begin
						for (int i = 0; i < MARKER_SLOTS; i++) begin
							if (action == ACT_CLEAR || life[i] < 0) begin
								active[i] = 1'b0;
								life[i] = life_reload;
							end
						end
					end
					ACT_DETECT: begin
						expected_q.push_back(track_detection(int'(rect_x), int'(rect_y),
							int'(rect_width), int'(rect_height)));
					end
					default: ;
				endcase
			end
			outstanding = expected_q.size();
		end
	end

endmodule

/* tb/sv/tb_detection_marker_tracker_core.sv */
`timescale 1ns / 100ps
// testbench top for the marker tracker: drives transactions and register writes, gives the verdict
module tb_detection_marker_tracker_core;
	import dmt_pkg::*;

	localparam int MARKER_SLOTS = 50;
	localparam int SETTLE_CYCLES = MARKER_SLOTS + 10;
	localparam int PHASE_ITEMS = 25;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic [1:0]           action = ACT_FRAME_START;
	logic [RECT_W-1:0]    rect_x = '0;
	logic [RECT_W-1:0]    rect_y = '0;
	logic [RECT_W-1:0]    rect_width = '0;
	logic [RECT_W-1:0]    rect_height = '0;
	logic                 cfg_valid = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_FRAME_WIDTH;
	logic [COORD_W-1:0]   cfg_data = '0;

	logic                 busy;
	logic                 done;
	logic [OUT_IDX_W-1:0] marker_index;
	logic                 slot_valid;
	logic                 is_new;
	logic [COORD_W-1:0]   center_x;
	logic [COORD_W-1:0]   center_y;
	logic [RAD_W-1:0]     radius;
	logic                 cfg_ready;

	int fail_count;
	int outstanding;
	int sent = 0;
	bit steady = 1'b0;

	always #5 clk = ~clk;

	detection_marker_tracker_core #(.MARKER_SLOTS(MARKER_SLOTS)) dut (.*);

	dmt_result_check #(.MARKER_SLOTS(MARKER_SLOTS)) tracker_mon (.*);

	function automatic logic [RECT_W-1:0] rnd_rect();
		return RECT_W'($urandom);
	endfunction

	task automatic send(input logic [1:0] act, input logic [RECT_W-1:0] x,
			input logic [RECT_W-1:0] y, input logic [RECT_W-1:0] w,
			input logic [RECT_W-1:0] h);
		start <= 1'b1;
		action <= act;
		rect_x <= x;
		rect_y <= y;
		rect_width <= w;
		rect_height <= h;
		@(posedge clk);
		while (busy) @(posedge clk);
		sent++;
		if (!steady && $urandom_range(0, 99) < 10) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 60)) @(posedge clk);
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COORD_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	task automatic set_regs(input logic [COORD_W-1:0] w, input logic [COORD_W-1:0] h,
			input logic [COORD_W-1:0] l);
		write_reg(CFG_FRAME_WIDTH, w);
		write_reg(CFG_FRAME_HEIGHT, h);
		write_reg(CFG_LIFETIME, l);
		cfg_valid <= 1'b0;
	endtask

	task automatic drain();
		start <= 1'b0;
		@(negedge clk);
		while (outstanding != 0 || busy) @(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic video_frame();
		send(ACT_FRAME_START, rnd_rect(), rnd_rect(), rnd_rect(), rnd_rect());
		repeat ($urandom_range(0, 5)) begin
			if ($urandom_range(0, 99) < 80)
				send(ACT_DETECT, RECT_W'(20 * $urandom_range(0, 8) + $urandom_range(0, 3)),
					RECT_W'(15 * $urandom_range(0, 8) + $urandom_range(0, 3)),
					RECT_W'($urandom_range(0, 40)), RECT_W'($urandom_range(0, 40)));
			else
				send(ACT_DETECT, rnd_rect(), rnd_rect(), rnd_rect(), rnd_rect());
		end
		send(ACT_FRAME_END, rnd_rect(), rnd_rect(), rnd_rect(), rnd_rect());
	endtask

	// distinct centers with zero radius, two past the table size
	task automatic fill_table();
		send(ACT_CLEAR, rnd_rect(), rnd_rect(), rnd_rect(), rnd_rect());
		for (int i = 0; i < MARKER_SLOTS + 2; i++)
			send(ACT_DETECT, RECT_W'(i), RECT_W'($urandom_range(0, 40)), '0, '0);
	endtask

	task automatic run_phase(input logic [COORD_W-1:0] w, input logic [COORD_W-1:0] h,
			input logic [COORD_W-1:0] l, input bit no_gaps, input bit fill_first);
		int goal;
		int pick;
		drain();
		set_regs(w, h, l);
		steady = no_gaps;
		if (fill_first)
			fill_table();
		goal = sent + PHASE_ITEMS;
		while (sent < goal) begin
			pick = $urandom_range(0, 99);
			if (pick < 78)
				video_frame();
			else if (pick < 90)
				send(2'($urandom_range(0, 3)), rnd_rect(), rnd_rect(), rnd_rect(),
					rnd_rect());
			else if (pick < 94)
				send(ACT_CLEAR, rnd_rect(), rnd_rect(), rnd_rect(), rnd_rect());
			else if (pick < 97)
				fill_table();
			else
				drain();
		end
		steady = 1'b0;
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// unknown index and zero lifetime writes must leave the defaults alone
		write_reg(CFG_UNUSED, COORD_W'($urandom));
		write_reg(CFG_LIFETIME, 13'd0);
		write_reg(CFG_LIFETIME, 13'h100);
		cfg_valid <= 1'b0;

		send(ACT_DETECT, '0, '0, '0, '0);
		send(ACT_DETECT, '0, '0, '0, '0);
		send(ACT_DETECT, '1, '1, '1, '1);
		send(ACT_DETECT, 12'd0, 12'd0, 12'd10, 12'd10);
		send(ACT_DETECT, 12'd246, 12'd184, 12'd0, 12'd1);
		send(ACT_DETECT, 12'd247, 12'd184, 12'd0, 12'd0);
		send(ACT_FRAME_START, '1, '1, '1, '1);
		send(ACT_FRAME_END, '1, '1, '1, '1);
		send(ACT_DETECT, 12'd2, 12'd2, 12'd6, 12'd6);
		repeat (6) send(ACT_FRAME_START, '0, '0, '0, '0);
		send(ACT_FRAME_END, '0, '0, '0, '0);
		send(ACT_DETECT, '0, '0, '0, '0);
		send(ACT_CLEAR, '1, '1, '1, '1);
		send(ACT_DETECT, '1, '0, '0, '0);
		send(ACT_DETECT, '0, '0, '0, '0);

		// life counter driven down to its floor, then freed
		drain();
		set_regs(13'd320, 13'd240, 13'd1);
		send(ACT_CLEAR, '0, '0, '0, '0);
		send(ACT_DETECT, 12'd10, 12'd10, '0, '0);
		repeat (260) send(ACT_FRAME_START, rnd_rect(), rnd_rect(), rnd_rect(), rnd_rect());
		send(ACT_FRAME_END, '0, '0, '0, '0);
		send(ACT_DETECT, 12'd10, 12'd10, '0, '0);

		run_phase(13'd8191, 13'd8191, 13'd255, 1'b0, 1'b1);
		run_phase(13'd0, 13'd0, 13'd1, 1'b0, 1'b0);
		run_phase(13'd320, 13'd240, 13'd5, 1'b1, 1'b0);
		run_phase(COORD_W'($urandom_range(60, 8191)), COORD_W'($urandom_range(60, 8191)),
			COORD_W'($urandom_range(1, 8)), 1'b0, 1'b1);
		run_phase(13'd100, 13'd8191, 13'd2, 1'b0, 1'b0);

		drain();
		if (fail_count == 0 && outstanding == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
